>>> rtl/core/ujq_pkg.sv
`default_nettype none

package ujq_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH      = 8;
    localparam int ID_WIDTH   = 16;
    localparam int PAGE_WIDTH = 16;

    // Fixed widths of the stream fields
    localparam int FIELD_W     = 16;
    localparam int OCC_W       = 4;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_PRINT  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESP,
        S_PRINT,
        S_LIST_OUT,
        S_LIST_RD
    } state_t;

    // One result item from the sequencer to the output register
    typedef struct packed {
        logic               valid;
        status_t            status;
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] pages;
        logic [OCC_W-1:0]   occ;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/ujq_mem.sv
`default_nettype none

module ujq_mem #(
    parameter int DEPTH = ujq_pkg::DEPTH,
    parameter int WIDTH = ujq_pkg::ID_WIDTH + ujq_pkg::PAGE_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ujq_ctrl.sv
`default_nettype none

module ujq_ctrl #(
    parameter int DEPTH      = ujq_pkg::DEPTH,
    parameter int ID_WIDTH   = ujq_pkg::ID_WIDTH,
    parameter int PAGE_WIDTH = ujq_pkg::PAGE_WIDTH,
    localparam int PTR_W     = $clog2(DEPTH),
    localparam int MW        = ID_WIDTH + PAGE_WIDTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire ujq_pkg::op_t                 in_op,
    input  wire logic [ujq_pkg::FIELD_W-1:0]  in_id,
    input  wire logic [ujq_pkg::FIELD_W-1:0]  in_pages,
    output ujq_pkg::res_t                     res,
    input  wire logic                         res_ready,
    output logic                              mem_wr_en,
    output logic      [PTR_W-1:0]             mem_wr_addr,
    output logic      [MW-1:0]                mem_wr_data,
    output logic                              mem_rd_en,
    output logic      [PTR_W-1:0]             mem_rd_addr,
    input  wire logic [MW-1:0]                mem_rd_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int FW    = ujq_pkg::FIELD_W;
    localparam int OW    = ujq_pkg::OCC_W;

    ujq_pkg::state_t  state_reg, state_next;
    ujq_pkg::status_t status_reg, status_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  rd_last_reg, rd_last_next;
    logic [ID_WIDTH-1:0]   id_reg, id_next;
    logic [PAGE_WIDTH-1:0] pages_reg, pages_next;

    logic [ID_WIDTH-1:0]   rd_id;
    logic [PAGE_WIDTH-1:0] rd_pages;
    logic [ID_WIDTH-1:0]   in_id_m;
    logic [PAGE_WIDTH-1:0] in_pages_m;

    assign rd_id      = mem_rd_data[MW-1:PAGE_WIDTH];
    assign rd_pages   = mem_rd_data[PAGE_WIDTH-1:0];
    assign in_id_m    = ID_WIDTH'(in_id);
    assign in_pages_m = PAGE_WIDTH'(in_pages);

    // slot of the entry that lies off places after base
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ujq_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= PTR_W'(DEPTH - 1);
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        idx_reg     <= idx_next;
        rd_last_reg <= rd_last_next;
        id_reg      <= id_next;
        pages_reg   <= pages_next;
    end

    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rd_last_next = rd_last_reg;
        id_next      = id_reg;
        pages_next   = pages_reg;

        in_ready    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = slot_of(tail_reg, CNT_W'(1));
        mem_wr_data = {id_reg, pages_reg};
        mem_rd_en   = 1'b0;
        mem_rd_addr = head_reg;

        res.valid  = 1'b0;
        res.status = status_reg;
        res.id     = '0;
        res.pages  = '0;
        res.occ    = OW'(count_reg);
        res.last   = 1'b1;

        case (state_reg)
            ujq_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    id_next    = in_id_m;
                    pages_next = in_pages_m;
                    case (in_op)
                        ujq_pkg::OP_ADD: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                status_next = ujq_pkg::ST_FULL;
                                state_next  = ujq_pkg::S_RESP;
                            end else if (count_reg == '0) begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = {in_id_m, in_pages_m};
                                tail_next   = mem_wr_addr;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = ujq_pkg::ST_OK;
                                state_next  = ujq_pkg::S_RESP;
                            end else begin
                                mem_rd_en    = 1'b1;
                                idx_next     = CNT_W'(1);
                                rd_last_next = (count_reg == CNT_W'(1));
                                state_next   = ujq_pkg::S_SCAN;
                            end
                        end
                        ujq_pkg::OP_PRINT: begin
                            if (count_reg == '0) begin
                                status_next = ujq_pkg::ST_EMPTY;
                                state_next  = ujq_pkg::S_RESP;
                            end else begin
                                // pop now; the result shows the count after the pop
                                mem_rd_en  = 1'b1;
                                head_next  = slot_of(head_reg, CNT_W'(1));
                                count_next = count_reg - CNT_W'(1);
                                state_next = ujq_pkg::S_PRINT;
                            end
                        end
                        ujq_pkg::OP_CANCEL: begin
                            head_next   = '0;
                            tail_next   = PTR_W'(DEPTH - 1);
                            count_next  = '0;
                            status_next = ujq_pkg::ST_OK;
                            state_next  = ujq_pkg::S_RESP;
                        end
                        ujq_pkg::OP_LIST: begin
                            if (count_reg == '0) begin
                                status_next = ujq_pkg::ST_EMPTY;
                                state_next  = ujq_pkg::S_RESP;
                            end else begin
                                mem_rd_en   = 1'b1;
                                idx_next    = CNT_W'(1);
                                status_next = ujq_pkg::ST_OK;
                                state_next  = ujq_pkg::S_LIST_OUT;
                            end
                        end
                        default: begin
                            state_next = ujq_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // one read issued per cycle, the previous one compared
            ujq_pkg::S_SCAN: begin
                if (rd_id == id_reg) begin
                    status_next = ujq_pkg::ST_DUP;
                    state_next  = ujq_pkg::S_RESP;
                end else if (rd_last_reg) begin
                    mem_wr_en   = 1'b1;
                    tail_next   = mem_wr_addr;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ujq_pkg::ST_OK;
                    state_next  = ujq_pkg::S_RESP;
                end else begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = slot_of(head_reg, idx_reg);
                    idx_next     = idx_reg + CNT_W'(1);
                    rd_last_next = ((idx_reg + CNT_W'(1)) == count_reg);
                end
            end

            ujq_pkg::S_RESP: begin
                res.valid = 1'b1;
                if (res_ready) begin
                    state_next = ujq_pkg::S_IDLE;
                end
            end

            ujq_pkg::S_PRINT: begin
                res.valid  = 1'b1;
                res.status = ujq_pkg::ST_OK;
                res.id     = FW'(rd_id);
                res.pages  = FW'(rd_pages);
                if (res_ready) begin
                    state_next = ujq_pkg::S_IDLE;
                end
            end

            ujq_pkg::S_LIST_OUT: begin
                res.valid  = 1'b1;
                res.status = ujq_pkg::ST_OK;
                res.id     = FW'(rd_id);
                res.pages  = FW'(rd_pages);
                res.last   = (idx_reg == count_reg);
                if (res_ready) begin
                    if (idx_reg == count_reg) begin
                        state_next = ujq_pkg::S_IDLE;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = slot_of(head_reg, idx_reg);
                        idx_next    = idx_reg + CNT_W'(1);
                        state_next  = ujq_pkg::S_LIST_RD;
                    end
                end
            end

            ujq_pkg::S_LIST_RD: begin
                state_next = ujq_pkg::S_LIST_OUT;
            end

            default: begin
                state_next = ujq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/unique_id_circular_job_queue_core.sv
// Circular job queue with a duplicate-ID check.
// Input stream (s_*): one item per operation. s_tdata, from bit 0 up:
//   op[1:0] (0 add, 1 print, 2 cancel, 3 list), job_id[17:2], page_count[33:18].
// Result stream (m_*): status, out_id, out_pages, occupancy in m_tdata;
//   m_tlast marks the final result item of an operation. Every operation gives
//   at least one item; a list gives one per queued job, head to tail.
// Jobs are kept in a single synchronous RAM (ID and page count side by side);
// one sequencer handles one operation at a time and s_tready is high only
// while it is idle.
// From acceptance to the first result item in the output register:
//   cancel, full, empty, add to an empty queue, print: straight to a result.
//   add to a non-empty queue: first an ID search, one RAM read a cycle over the
//   queued jobs; a duplicate ends the search early.
//   list: each further item is read from the RAM after the one before is taken.
// The sequencer returns to idle before the next accept.
// Reset (aresetn low, synchronous) empties the queue; the RAM is not cleared.
// A stalled receiver holds the output register, and the sequencer waits.
`default_nettype none

module unique_id_circular_job_queue_core #(
    parameter int DEPTH      = ujq_pkg::DEPTH,
    parameter int ID_WIDTH   = ujq_pkg::ID_WIDTH,
    parameter int PAGE_WIDTH = ujq_pkg::PAGE_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // op[1:0], job_id[17:2], page_count[33:18], zero[39:34]
    input  wire logic [ujq_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status[1:0], out_id[17:2], out_pages[33:18], occupancy[37:34], zero[39:38]
    output logic      [ujq_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                                m_tlast
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int MW    = ID_WIDTH + PAGE_WIDTH;
    localparam int FW    = ujq_pkg::FIELD_W;
    localparam int OW    = ujq_pkg::OCC_W;
    localparam int PAD_W = ujq_pkg::M_TDATA_W - 2 - 2 * FW - OW;

    ujq_pkg::res_t res;
    logic          res_ready;

    logic             mem_wr_en;
    logic [PTR_W-1:0] mem_wr_addr;
    logic [MW-1:0]    mem_wr_data;
    logic             mem_rd_en;
    logic [PTR_W-1:0] mem_rd_addr;
    logic [MW-1:0]    mem_rd_data;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [ujq_pkg::M_TDATA_W-1:0]   m_tdata_reg;
    logic                            m_tlast_reg;

    ujq_ctrl #(
        .DEPTH      (DEPTH),
        .ID_WIDTH   (ID_WIDTH),
        .PAGE_WIDTH (PAGE_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (ujq_pkg::op_t'(s_tdata[1:0])),
        .in_id       (s_tdata[FW+1:2]),
        .in_pages    (s_tdata[2*FW+1:FW+2]),
        .res         (res),
        .res_ready   (res_ready),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    ujq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (MW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register: takes an item whenever it is empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_ready) begin
            m_tvalid_next = res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid && res_ready) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, res.occ, res.pages, res.id, res.status};
            m_tlast_reg <= res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

>>> rtl/core/ujq_chk.sv
`default_nettype none

module ujq_chk #(
    parameter int DEPTH = ujq_pkg::DEPTH
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ujq_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);

    localparam int FW = ujq_pkg::FIELD_W;
    localparam int OW = ujq_pkg::OCC_W;
    localparam int OCC_LO = 2 + 2 * FW;

    logic [1:0]    st;
    logic [OW-1:0] occ;

    assign st  = m_tdata[1:0];
    assign occ = m_tdata[OCC_LO+OW-1:OCC_LO];

    // no result item may survive reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // rejections and empty reports are single-item answers
    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st != ujq_pkg::ST_OK) |-> m_tlast)
        else $error("non-ok status without last");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ujq_pkg::ST_EMPTY) |->
            (occ == '0) && (m_tdata[2*FW+1:2] == '0))
        else $error("empty status with data or occupancy");

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (occ <= OW'(DEPTH)))
        else $error("occupancy beyond depth");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result item changed");

endmodule

bind unique_id_circular_job_queue_core ujq_chk #(
    .DEPTH (DEPTH)
) u_ujq_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/unique_id_circular_job_queue_core_tb.sv
`timescale 1ns / 100ps

module unique_id_circular_job_queue_core_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 385;
    localparam int DEPTH       = ujq_pkg::DEPTH;
    localparam int S_TDATA_W   = ujq_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = ujq_pkg::M_TDATA_W;

    typedef struct {
        ujq_pkg::status_t status;
        logic [15:0]      id;
        logic [15:0]      pages;
        logic [3:0]       occ;
        logic             last;
    } job_res_t;

    typedef struct packed {
        ujq_pkg::op_t     op;
        logic [15:0]      id;
        logic [15:0]      pages;
        logic             has_exp;
        ujq_pkg::status_t st;
        logic [3:0]       occ;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    // queue shadow
    logic [15:0] q_id [DEPTH];
    logic [15:0] q_pg [DEPTH];
    int unsigned q_head, q_tail, q_count;

    job_res_t    pending_res[$];
    stim_row_t   dir_tab[$];

    int err_count    = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int cycle_count  = 0;
    int n_list = 0, n_full = 0, n_dup = 0, n_pop = 0;
    bit burst = 1'b0;

    unique_id_circular_job_queue_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_res.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic stim_row_t mk_row(input ujq_pkg::op_t op, input logic [15:0] id,
                                         input logic [15:0] pages, input logic has_exp,
                                         input ujq_pkg::status_t st,
                                         input logic [3:0] occ);
        stim_row_t r;
        r.op      = op;
        r.id      = id;
        r.pages   = pages;
        r.has_exp = has_exp;
        r.st      = st;
        r.occ     = occ;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("MISMATCH result %0d: %s got %0h want %0h", results_seen, what, got, want);
    endtask

    // Works out the result items of one operation and advances the shadow queue
    task automatic predict_job_op(input ujq_pkg::op_t op, input logic [15:0] id,
                                  input logic [15:0] pages);
        job_res_t    r;
        bit          dup;
        int unsigned slot;
        r.status = ujq_pkg::ST_OK;
        r.id     = '0;
        r.pages  = '0;
        r.last   = 1'b1;
        case (op)
            ujq_pkg::OP_ADD: begin
                if (q_count >= DEPTH) begin
                    r.status = ujq_pkg::ST_FULL;
                    n_full++;
                end else begin
                    dup = 1'b0;
                    for (int i = 0; i < q_count; i++)
                        if (q_id[(q_head + i) % DEPTH] == id) dup = 1'b1;
                    if (dup) begin
                        r.status = ujq_pkg::ST_DUP;
                        n_dup++;
                    end else begin
                        q_tail = (q_tail + 1) % DEPTH;
                        q_id[q_tail] = id;
                        q_pg[q_tail] = pages;
                        q_count++;
                    end
                end
                r.occ = q_count[3:0];
                pending_res.push_back(r);
            end
            ujq_pkg::OP_PRINT: begin
                if (q_count == 0) begin
                    r.status = ujq_pkg::ST_EMPTY;
                end else begin
                    r.id    = q_id[q_head];
                    r.pages = q_pg[q_head];
                    q_head  = (q_head + 1) % DEPTH;
                    q_count--;
                    n_pop++;
                end
                r.occ = q_count[3:0];
                pending_res.push_back(r);
            end
            ujq_pkg::OP_CANCEL: begin
                q_head  = 0;
                q_tail  = DEPTH - 1;
                q_count = 0;
                r.occ   = '0;
                pending_res.push_back(r);
            end
            default: begin
                r.occ = q_count[3:0];
                if (q_count == 0) begin
                    r.status = ujq_pkg::ST_EMPTY;
                    pending_res.push_back(r);
                end else begin
                    n_list++;
                    for (int i = 0; i < q_count; i++) begin
                        slot    = (q_head + i) % DEPTH;
                        r.id    = q_id[slot];
                        r.pages = q_pg[slot];
                        r.last  = (i == q_count - 1);
                        pending_res.push_back(r);
                    end
                end
            end
        endcase
    endtask

    // Offers one item, holds it until accepted, returns at the next falling edge
    task automatic send_job(input stim_row_t row);
        job_res_t r;
        s_tdata  <= {6'b0, row.pages, row.id, row.op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_job_op(row.op, row.id, row.pages);
        if (row.has_exp) begin
            // typed rows are single-item results: the typed value stands in
            r = pending_res.pop_back();
            r.status = row.st;
            r.occ    = row.occ;
            r.id     = '0;
            r.pages  = '0;
            r.last   = 1'b1;
            pending_res.push_back(r);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic idle_sender();
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        job_res_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected item, status", m_tdata[1:0], 0);
            end else begin
                w = pending_res.pop_front();
                if (m_tdata[1:0] != w.status)  report_mismatch("status", m_tdata[1:0], w.status);
                if (m_tdata[17:2] != w.id)     report_mismatch("out_id", m_tdata[17:2], w.id);
                if (m_tdata[33:18] != w.pages) report_mismatch("out_pages", m_tdata[33:18], w.pages);
                if (m_tdata[37:34] != w.occ)   report_mismatch("occupancy", m_tdata[37:34], w.occ);
                if (m_tlast != w.last)         report_mismatch("last", m_tlast, w.last);
            end
            results_seen++;
        end
    end

    // receiver: random stalls plus one long hold-off once traffic is flowing
    initial begin
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= 40) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (burst) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        stim_row_t row;
        int        r;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        q_head   = 0;
        q_tail   = DEPTH - 1;
        q_count  = 0;

        dir_tab.push_back(mk_row(ujq_pkg::OP_PRINT,  16'h0000, 16'h0000, 1,
                                 ujq_pkg::ST_EMPTY, 4'd0));
        dir_tab.push_back(mk_row(ujq_pkg::OP_LIST,   16'hFFFF, 16'hFFFF, 1,
                                 ujq_pkg::ST_EMPTY, 4'd0));
        dir_tab.push_back(mk_row(ujq_pkg::OP_ADD,    16'h0000, 16'h0000, 1,
                                 ujq_pkg::ST_OK,    4'd1));
        dir_tab.push_back(mk_row(ujq_pkg::OP_ADD,    16'hFFFF, 16'hFFFF, 1,
                                 ujq_pkg::ST_OK,    4'd2));
        dir_tab.push_back(mk_row(ujq_pkg::OP_ADD,    16'h0000, 16'h1234, 1,
                                 ujq_pkg::ST_DUP,   4'd2));
        dir_tab.push_back(mk_row(ujq_pkg::OP_LIST,   16'h0000, 16'h0000, 0,
                                 ujq_pkg::ST_OK,    4'd0));
        dir_tab.push_back(mk_row(ujq_pkg::OP_PRINT,  16'h0000, 16'h0000, 0,
                                 ujq_pkg::ST_OK,    4'd0));
        // tail wraps round to slot 0 on the last of these
        for (int i = 1; i <= 7; i++)
            dir_tab.push_back(mk_row(ujq_pkg::OP_ADD, i[15:0], 16'h1111 * i[15:0], 1,
                                     ujq_pkg::ST_OK, 4'(i + 1)));
        // full queue: full is reported even for an ID already queued
        dir_tab.push_back(mk_row(ujq_pkg::OP_ADD,    16'h1234, 16'h4321, 1,
                                 ujq_pkg::ST_FULL,  4'd8));
        dir_tab.push_back(mk_row(ujq_pkg::OP_ADD,    16'hFFFF, 16'h0001, 1,
                                 ujq_pkg::ST_FULL,  4'd8));
        dir_tab.push_back(mk_row(ujq_pkg::OP_LIST,   16'h0000, 16'h0000, 0,
                                 ujq_pkg::ST_OK,    4'd0));
        dir_tab.push_back(mk_row(ujq_pkg::OP_PRINT,  16'h0000, 16'h0000, 0,
                                 ujq_pkg::ST_OK,    4'd0));
        dir_tab.push_back(mk_row(ujq_pkg::OP_ADD,    16'h0007, 16'h0000, 1,
                                 ujq_pkg::ST_DUP,   4'd7));
        // refill with the queue spanning the wrap point
        dir_tab.push_back(mk_row(ujq_pkg::OP_ADD,    16'hAAAA, 16'h5555, 1,
                                 ujq_pkg::ST_OK,    4'd8));
        dir_tab.push_back(mk_row(ujq_pkg::OP_LIST,   16'h0000, 16'h0000, 0,
                                 ujq_pkg::ST_OK,    4'd0));
        dir_tab.push_back(mk_row(ujq_pkg::OP_CANCEL, 16'hC3C3, 16'h3C3C, 1,
                                 ujq_pkg::ST_OK,    4'd0));
        dir_tab.push_back(mk_row(ujq_pkg::OP_PRINT,  16'h0000, 16'h0000, 1,
                                 ujq_pkg::ST_EMPTY, 4'd0));
        dir_tab.push_back(mk_row(ujq_pkg::OP_ADD,    16'h5555, 16'hAAAA, 1,
                                 ujq_pkg::ST_OK,    4'd1));
        dir_tab.push_back(mk_row(ujq_pkg::OP_LIST,   16'h0000, 16'h0000, 0,
                                 ujq_pkg::ST_OK,    4'd0));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i]) begin
            send_job(dir_tab[i]);
            idle_sender();
        end

        for (int k = 0; k < RAND_ITEMS; k++) begin
            burst = ((k % 100) >= 80);
            if (k == 200) begin
                // let the block drain completely before carrying on
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (pending_res.size() != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 45)      row.op = ujq_pkg::OP_ADD;
            else if (r < 70) row.op = ujq_pkg::OP_PRINT;
            else if (r < 90) row.op = ujq_pkg::OP_LIST;
            else             row.op = ujq_pkg::OP_CANCEL;
            // small ID pool so duplicates turn up often
            row.id      = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 11))
                                                     : 16'($urandom);
            row.pages   = 16'($urandom);
            row.has_exp = 1'b0;
            row.st      = ujq_pkg::ST_OK;
            row.occ     = '0;
            send_job(row);
            idle_sender();
        end
        burst = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_res.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (pending_res.size() != 0)
            report_mismatch("items left over", pending_res.size(), 0);

        $display("Covered %0d operations and %0d result items: %0d non-empty lists, %0d pops,",
                 items_sent, results_seen, n_list, n_pop);
        $display("%0d full rejects and %0d duplicate rejects, with stalls on both streams.",
                 n_full, n_dup);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
